>>> hdl/drsa_pkg.sv
// shared types and codes for the deferred-reuse slot allocator
package drsa_pkg;

  // request function codes
  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_UPDATE = 2'd1;
  localparam logic [1:0] FN_FREE   = 2'd2;
  // unassigned code, answered as ignored
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // result status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_FULL    = 3'd1;
  localparam logic [2:0] STS_RANGE   = 3'd2;
  localparam logic [2:0] STS_DOUBLE  = 3'd3;
  localparam logic [2:0] STS_NULL    = 3'd4;
  localparam logic [2:0] STS_IGNORED = 3'd5;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REPORT
  } op_t;

  // classified command
  typedef struct packed {
    op_t         op;
    logic [1:0]  pool;
    logic [9:0]  slot;
    logic [2:0]  status;
    logic        zero_occ;
    logic [63:0] frame;
    logic [63:0] reuse;
  } cmd_t;

  // finished result
  typedef struct packed {
    logic [9:0]  slot;
    logic [2:0]  status;
    logic [10:0] occ;
  } res_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_A_RD,
    ST_A_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_F_RD,
    ST_F_CHK,
    ST_EMIT
  } st_t;

endpackage

>>> hdl/drsa_fifo.sv
// small register queue with push/full and pop/empty
module drsa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wp_r] <= push_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> hdl/drsa_front.sv
// request classification, stateless checks and config register
module drsa_front #(
  parameter int POOL_COUNT = 4,
  parameter int MAX_SLOTS  = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_data,
  input  logic [1:0]    func,
  input  logic [1:0]    pool_index,
  input  logic [9:0]    slot_index,
  input  logic          no_slot,
  input  logic [31:0]   resource_id,
  input  logic [63:0]   frame_number,
  output drsa_pkg::cmd_t cmd
);
  import drsa_pkg::*;

  logic [2:0] in_flight_r;
  logic       pool_bad;
  logic       res_null;

  assign cfg_ready = 1'b1;

  // in-flight frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= 3'd2;
    end else if (cfg_valid) begin
      in_flight_r <= cfg_data;
    end
  end

  assign pool_bad = (32'(pool_index) >= 32'(POOL_COUNT));
  assign res_null = (resource_id == '0);

  // classify
  always_comb begin
    cmd.pool     = pool_index;
    cmd.slot     = slot_index;
    cmd.frame    = frame_number;
    cmd.reuse    = frame_number + 64'(in_flight_r) + 64'd1;
    cmd.zero_occ = pool_bad;
    cmd.op       = OP_REPORT;
    cmd.status   = STS_IGNORED;
    if (!pool_bad) begin
      case (func)
        FN_ALLOC: begin
          if (res_null) begin
            cmd.slot   = '0;
            cmd.status = STS_NULL;
          end else begin
            cmd.op     = OP_ALLOC;
            cmd.status = STS_OK;
          end
        end
        FN_UPDATE: begin
          if (32'(slot_index) >= 32'(MAX_SLOTS)) begin
            cmd.status = STS_RANGE;
          end else if (res_null) begin
            cmd.status = STS_NULL;
          end else begin
            cmd.status = STS_OK;
          end
        end
        FN_FREE: begin
          if (!no_slot) begin
            cmd.op     = OP_FREE;
            cmd.status = STS_OK;
          end
        end
        default: cmd.status = STS_IGNORED;
      endcase
    end
  end
endmodule

>>> hdl/drsa_back.sv
// free-list sequencer: search, compaction, double-free scan and append
module drsa_back #(
  parameter int POOL_COUNT = 4,
  parameter int MAX_SLOTS  = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  drsa_pkg::cmd_t cmd_head,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output drsa_pkg::res_t res
);
  import drsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int PL_W  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int ENT_W = IDX_W + 64;

  st_t state_r;
  st_t state_nxt;

  cmd_t              cmd_r;
  res_t              res_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  occ_r [POOL_COUNT];
  logic [CNT_W-1:0]  len_r [POOL_COUNT];
  logic [ENT_W-1:0]  mem [1 << (PL_W + IDX_W)];
  logic [ENT_W-1:0]  rd_data_r;

  logic [PL_W-1:0]   pool_sel;
  logic [CNT_W-1:0]  occ_cur;
  logic [CNT_W-1:0]  len_cur;
  logic [IDX_W-1:0]  len_m1;
  logic [IDX_W-1:0]  rd_slot;
  logic [63:0]       rd_reuse;
  logic              slot_lt_occ;
  logic              hit_reuse;
  logic              hit_slot;
  logic              at_last;
  logic              len_full;
  logic              occ_full;

  logic              mem_we;
  logic [PL_W+IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;

  // current-pool views
  assign pool_sel    = PL_W'(cmd_r.pool);
  assign occ_cur     = cmd_r.zero_occ ? '0 : occ_r[pool_sel];
  assign len_cur     = cmd_r.zero_occ ? '0 : len_r[pool_sel];
  assign len_m1      = IDX_W'(len_cur - 1'b1);
  assign rd_slot     = rd_data_r[ENT_W-1:64];
  assign rd_reuse    = rd_data_r[63:0];
  assign slot_lt_occ = (32'(cmd_r.slot) < 32'(occ_cur));
  assign hit_reuse   = (cmd_r.frame >= rd_reuse);
  assign hit_slot    = (32'(rd_slot) == 32'(cmd_r.slot));
  assign at_last     = (idx_r == len_m1);
  assign len_full    = (32'(len_cur) >= 32'(MAX_SLOTS));
  assign occ_full    = (32'(occ_cur) >= 32'(MAX_SLOTS));

  // free-list memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[{pool_sel, idx_r}];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (!cmd_empty) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (cmd_r.op)
          OP_ALLOC: state_nxt = (len_cur != '0) ? ST_A_RD : ST_EMIT;
          OP_FREE:  state_nxt = (slot_lt_occ && len_cur != '0) ? ST_F_RD : ST_EMIT;
          default:  state_nxt = ST_EMIT;
        endcase
      end
      ST_A_RD:     state_nxt = ST_A_CHK;
      ST_A_CHK: begin
        if (hit_reuse) begin
          state_nxt = at_last ? ST_EMIT : ST_SH_RD;
        end else begin
          state_nxt = (idx_r == '0) ? ST_EMIT : ST_A_RD;
        end
      end
      ST_SH_RD:    state_nxt = ST_SH_WR;
      ST_SH_WR:    state_nxt = at_last ? ST_EMIT : ST_SH_RD;
      ST_F_RD:     state_nxt = ST_F_CHK;
      ST_F_CHK:    state_nxt = (hit_slot || at_last) ? ST_EMIT : ST_F_RD;
      ST_EMIT:     if (!res_full) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory write control
  always_comb begin
    cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
    res_push  = (state_r == ST_EMIT);
    res       = res_r;
    mem_we    = 1'b0;
    mem_waddr = {pool_sel, IDX_W'(len_cur)};
    mem_wdata = {IDX_W'(cmd_r.slot), cmd_r.reuse};
    unique case (state_r)
      ST_DISPATCH: mem_we = (cmd_r.op == OP_FREE) && slot_lt_occ &&
                            (len_cur == '0) && !len_full;
      ST_F_CHK:    mem_we = !hit_slot && at_last && !len_full;
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {pool_sel, idx_r - 1'b1};
        mem_wdata = rd_data_r;
      end
      default:     mem_we = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pool counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        occ_r[p] <= '0;
        len_r[p] <= '0;
      end
    end else begin
      // bump occupancy when allocate finds no reusable entry
      if (!occ_full && cmd_r.op == OP_ALLOC &&
          ((state_r == ST_DISPATCH && len_cur == '0) ||
           (state_r == ST_A_CHK && !hit_reuse && idx_r == '0))) begin
        occ_r[pool_sel] <= occ_cur + 1'b1;
      end
      if (mem_we && state_r != ST_SH_WR) begin
        len_r[pool_sel] <= len_cur + 1'b1;
      end
      if ((state_r == ST_A_CHK && hit_reuse && at_last) ||
          (state_r == ST_SH_WR && at_last)) begin
        len_r[pool_sel] <= len_cur - 1'b1;
      end
    end
  end

  // command, index and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r <= cmd_head;
      end
      ST_DISPATCH: begin
        case (cmd_r.op)
          OP_ALLOC: begin
            idx_r <= len_m1;
            if (occ_full) begin
              res_r <= '{slot: '0, status: STS_FULL, occ: 11'(occ_cur)};
            end else begin
              res_r <= '{slot: 10'(occ_cur), status: STS_OK, occ: 11'(occ_cur + 1'b1)};
            end
          end
          OP_FREE: begin
            idx_r <= '0;
            if (!slot_lt_occ) begin
              res_r <= '{slot: cmd_r.slot, status: STS_RANGE, occ: 11'(occ_cur)};
            end else if (len_full) begin
              res_r <= '{slot: cmd_r.slot, status: STS_DOUBLE, occ: 11'(occ_cur)};
            end else begin
              res_r <= '{slot: cmd_r.slot, status: STS_OK, occ: 11'(occ_cur)};
            end
          end
          default: begin
            res_r <= '{slot: cmd_r.slot, status: cmd_r.status, occ: 11'(occ_cur)};
          end
        endcase
      end
      ST_A_CHK: begin
        if (hit_reuse) begin
          res_r <= '{slot: 10'(rd_slot), status: STS_OK, occ: 11'(occ_cur)};
          idx_r <= idx_r + 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
      ST_SH_WR: begin
        idx_r <= idx_r + 1'b1;
      end
      ST_F_CHK: begin
        if (hit_slot) begin
          res_r <= '{slot: cmd_r.slot, status: STS_DOUBLE, occ: 11'(occ_cur)};
        end
        idx_r <= idx_r + 1'b1;
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // search and scan only touch live entries
  a_chk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_A_CHK || state_r == ST_F_CHK) |-> 32'(idx_r) < 32'(len_cur))
    else $error("free-list read beyond list length");

  // compaction never writes below the list base
  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SH_WR) |-> idx_r != '0)
    else $error("compaction write below entry zero");

  // free list never outgrows the used slots
  a_len_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && cmd_r.op != OP_REPORT) |-> len_cur <= occ_cur)
    else $error("free list longer than occupancy");

  // a result is pushed only from the emit state and then the block goes idle
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_full) |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after result");
`endif
endmodule

>>> hdl/deferred_reuse_slot_allocator.sv
// top level: front classifier, command queue, free-list sequencer, result queue
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  in       | in_push / in_full      | func, pool_index, slot_index, no_slot, ids, frame
//  out      | out_pop / out_empty    | granted_slot, status, occupancy
//  cfg      | cfg_valid / cfg_ready  | in_flight_frames (3 bits)
//
// the sequencer finishes one item before it takes the next, visiting free-list entries in turn:
// allocate walks the list newest first and then shifts the entries above the hit down,
// free scans the list for a duplicate until it finds one or reaches the end of the list.
// rst_n is synchronous; counters clear at once, the free list needs no clearing pass.
// a 4-deep command queue and a 4-deep result queue let either side stall on its own.
module deferred_reuse_slot_allocator #(
  parameter int POOL_COUNT = 4,
  parameter int MAX_SLOTS  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_pool_index,
  input  logic [9:0]  in_slot_index,
  input  logic        in_no_slot,
  input  logic [31:0] in_resource_id,
  input  logic [63:0] in_frame_number,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [9:0]  out_granted_slot,
  output logic [2:0]  out_status,
  output logic [10:0] out_occupancy
);
  import drsa_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  drsa_front #(.POOL_COUNT(POOL_COUNT), .MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .func         (in_func),
    .pool_index   (in_pool_index),
    .slot_index   (in_slot_index),
    .no_slot      (in_no_slot),
    .resource_id  (in_resource_id),
    .frame_number (in_frame_number),
    .cmd          (cmd_in)
  );

  drsa_fifo #(.W($bits(cmd_t)), .DEPTH(4)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (cmd_in),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  drsa_back #(.POOL_COUNT(POOL_COUNT), .MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  drsa_fifo #(.W($bits(res_t)), .DEPTH(4)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty)
  );

  assign out_granted_slot = res_head.slot;
  assign out_status       = res_head.status;
  assign out_occupancy    = res_head.occ;
endmodule
